@@ rtl/held_note_step_table_populator_top_assert.svh @@
// Assertion macros for the held-note step table populator checker.
`ifndef HELD_NOTE_STEP_TABLE_POPULATOR_TOP_ASSERT_SVH
`define HELD_NOTE_STEP_TABLE_POPULATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define HNSTP_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define HNSTP_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hnstp_pkg.sv @@
// Shared types, codes and helpers for the held-note step table populator.
package hnstp_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int OUT_LIMIT     = 16;   // most writes per note-on
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 5;    // holds 0..31
    localparam int NOTE_W        = 7;
    localparam int VAL_W         = 8;
    localparam int ACT_W         = 8;

    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_PLAYED = 3'd1;
    localparam logic [2:0] MODE_ASC    = 3'd2;
    localparam logic [2:0] MODE_DESC   = 3'd3;
    localparam logic [2:0] MODE_CHROM  = 3'd4;
    localparam logic [2:0] MODE_PING   = 3'd5;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_STEPS = 1'b1;

    localparam logic KIND_ON  = 1'b0;
    localparam logic KIND_OFF = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DIV,
        ST_EMIT
    } hnstp_state_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_LOAD,
        ROW_SORT,
        ROW_SHIFT
    } row_op_t;

    typedef struct packed {
        logic             vld;
        logic [VAL_W-1:0] val;
    } cell_key_t;

    typedef struct packed {
        row_op_t op;
        logic    parity;   // which neighbor pairs compare this round
        logic    desc;
    } row_ctrl_t;

    // true when a (lower position) and b (upper position) must swap;
    // empty keys sink to the far end of the row
    function automatic logic key_ooo(cell_key_t a, cell_key_t b, logic desc);
        logic r;
        if (!a.vld) begin
            r = b.vld;
        end else if (!b.vld) begin
            r = 1'b0;
        end else begin
            r = desc ? (a.val < b.val) : (a.val > b.val);
        end
        return r;
    endfunction

endpackage

@@ rtl/hnstp_cell.sv @@
// One cell of the note row: load, compare-exchange with a neighbor, or shift.
module hnstp_cell import hnstp_pkg::*; (
    input  logic      aclk,
    input  row_op_t   op,
    input  logic      desc,
    input  logic      lower,   // paired with the right neighbor this round
    input  logic      upper,   // paired with the left neighbor this round
    input  cell_key_t ld,
    input  cell_key_t left,
    input  cell_key_t right,
    output cell_key_t key
);

    cell_key_t key_reg, key_next;

    always_comb begin
        key_next = key_reg;
        unique case (op)
            ROW_HOLD:  key_next = key_reg;
            ROW_LOAD:  key_next = ld;
            ROW_SHIFT: key_next = right;
            ROW_SORT: begin
                if (lower && key_ooo(key_reg, right, desc)) begin
                    key_next = right;
                end else if (upper && key_ooo(left, key_reg, desc)) begin
                    key_next = left;
                end
            end
            default:   key_next = key_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

@@ rtl/hnstp_row.sv @@
// Row of note cells: odd-even transposition sort and shift-out toward cell 0.
module hnstp_row import hnstp_pkg::*; #(
    parameter int CELLS = OUT_LIMIT
) (
    input  logic      aclk,
    input  row_ctrl_t ctrl,
    input  cell_key_t ld [CELLS],
    output cell_key_t head
);

    localparam cell_key_t KEY_EMPTY = '{vld: 1'b0, val: '0};

    cell_key_t keys [CELLS];

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        cell_key_t left_key, right_key;
        logic      lower, upper;

        if (g == 0) begin : g_first
            assign left_key = KEY_EMPTY;
        end else begin : g_mid_l
            assign left_key = keys[g-1];
        end

        if (g == CELLS - 1) begin : g_last
            assign right_key = KEY_EMPTY;
        end else begin : g_mid_r
            assign right_key = keys[g+1];
        end

        assign lower = (ctrl.parity == 1'(g % 2)) && (g < CELLS - 1);
        assign upper = (ctrl.parity != 1'(g % 2)) && (g > 0);

        hnstp_cell u_cell (
            .aclk  (aclk),
            .op    (ctrl.op),
            .desc  (ctrl.desc),
            .lower (lower),
            .upper (upper),
            .ld    (ld[g]),
            .left  (left_key),
            .right (right_key),
            .key   (keys[g])
        );
    end

    assign head = keys[0];

endmodule

@@ rtl/hnstp_rem.sv @@
// Restoring remainder unit: 8-bit dividend by 5-bit divisor, one bit per cycle.
module hnstp_rem import hnstp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACT_W-1:0] dividend,
    input  logic [4:0]       divisor,
    output logic             done,
    output logic [4:0]       rem
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [ACT_W-1:0] dvd_reg, dvd_next;
    logic [4:0]       r_reg, r_next;
    logic [4:0]       d_reg, d_next;
    logic [5:0]       trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, dvd_reg[ACT_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor, so five bits suffice
            if (trial >= {1'b0, d_reg}) begin
                r_next = 5'(trial - {1'b0, d_reg});
            end else begin
                r_next = trial[4:0];
            end
            dvd_next = {dvd_reg[ACT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

@@ rtl/held_note_step_table_populator_top.sv @@
// Held-note step table populator: top level.
// Input stream s_*: one MIDI event per transfer, tuser = kind (0 note-on, 1 note-off),
// tdata = note number. Output stream m_*: step table writes, tlast on the final
// write caused by one note-on. Config channel cfg_*: index 0 populate mode,
// index 1 step count; always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. A note-off writes nothing.
// A note-on loads the cell row, then:
//   ascending / descending: min(16, MAX_STEPS) sort rounds in the cell row, then
//     one write per cycle while the receiver is ready, for the sorted notes (up to 16);
//   chromatic run: one write per cycle while the receiver is ready, for every step in use;
//   as played / ping-pong: 8 bit steps in the bit-serial remainder unit, then its done
//     flag, then one write (none for ping-pong with one step).
// s_tready is high only between note-ons being processed; the output register lets a
// new event in while the last write still waits.
// A stalled receiver holds the write in the output register and freezes the
// cell row. Reset empties the history and held count, sets mode off and 16 steps.
module held_note_step_table_populator_top import hnstp_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [6:0] note_number, [7] zero
    input  logic        s_tuser,    // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] step_index, [11:4] write_note, [15:12] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int CELLS = (MAX_STEPS < OUT_LIMIT) ? MAX_STEPS : OUT_LIMIT;
    localparam int HL_W  = $clog2(MAX_STEPS + 1);
    localparam int CW    = (HL_W > CNT_W) ? HL_W : CNT_W;

    hnstp_state_t state_reg, state_next;

    logic [2:0]        mode_reg;
    logic [CNT_W-1:0]  steps_cfg_reg;
    logic [NOTE_W-1:0] hist_reg [MAX_STEPS];
    logic [HL_W-1:0]   hist_len_reg, hist_len_next;
    logic [ACT_W-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]  round_reg, round_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  fix_idx_reg, fix_idx_next;
    logic              single_reg, single_next;

    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_index_reg, m_index_next;
    logic [VAL_W-1:0]  m_note_reg, m_note_next;
    logic              m_last_reg, m_last_next;

    logic              in_fire, on_fire, off_fire, emit_fire, out_free;
    logic [NOTE_W-1:0] note_in;
    logic [HL_W-1:0]   len_inc;
    logic [ACT_W-1:0]  act_inc, act_dec;
    logic [CNT_W-1:0]  steps_eff, n_sort;
    logic [4:0]        period, divisor;
    logic              div_start, div_done;
    logic [4:0]        div_rem;
    row_ctrl_t         row_ctrl;
    cell_key_t         ld [CELLS];
    cell_key_t         head;

    assign note_in   = s_tdata[NOTE_W-1:0];
    assign in_fire   = s_tvalid && s_tready;
    assign on_fire   = in_fire && (s_tuser == KIND_ON);
    assign off_fire  = in_fire && (s_tuser == KIND_OFF);
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    assign steps_eff = (steps_cfg_reg > CNT_W'(CELLS)) ? CNT_W'(CELLS) : steps_cfg_reg;
    assign period    = 5'({steps_eff - CNT_W'(1), 1'b0});
    assign act_inc   = (active_reg == '1) ? active_reg : active_reg + ACT_W'(1);
    assign act_dec   = (active_reg == '0) ? active_reg : active_reg - ACT_W'(1);
    assign len_inc   = (hist_len_reg < HL_W'(MAX_STEPS)) ? hist_len_reg + HL_W'(1)
                                                         : hist_len_reg;
    assign n_sort    = (CW'(len_inc) < CW'(steps_eff)) ? CNT_W'(len_inc) : steps_eff;
    assign divisor   = (mode_reg == MODE_PLAYED) ? 5'(steps_eff) : period;

    // row load values: newest note in cell 0, history behind it; in chromatic mode the note plus the cell index
    for (genvar g = 0; g < CELLS; g++) begin : g_ld
        logic [VAL_W-1:0] hist_val;
        if (g == 0) begin : g_head
            assign hist_val = VAL_W'(note_in);
        end else begin : g_tail
            assign hist_val = VAL_W'(hist_reg[g-1]);
        end
        always_comb begin
            if (mode_reg == MODE_CHROM) begin
                ld[g].val = VAL_W'(note_in) + VAL_W'(g);
                ld[g].vld = steps_eff > CNT_W'(g);
            end else begin
                ld[g].val = hist_val;
                ld[g].vld = n_sort > CNT_W'(g);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (on_fire && (steps_eff != '0)) begin
                    unique case (mode_reg)
                        MODE_ASC, MODE_DESC: state_next = ST_SORT;
                        MODE_CHROM:          state_next = ST_EMIT;
                        MODE_PLAYED:         state_next = ST_DIV;
                        MODE_PING: begin
                            state_next = (steps_eff > CNT_W'(1)) ? ST_DIV : ST_IDLE;
                        end
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SORT: begin
                if (round_reg == CNT_W'(CELLS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire && (remain_reg == CNT_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready        = (state_reg == ST_IDLE);
        row_ctrl.op     = ROW_HOLD;
        row_ctrl.parity = round_reg[0];
        row_ctrl.desc   = (mode_reg == MODE_DESC);
        div_start       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (on_fire) begin
                    row_ctrl.op = ROW_LOAD;
                    div_start   = (mode_reg == MODE_PLAYED) || (mode_reg == MODE_PING);
                end
            end
            ST_SORT: row_ctrl.op = ROW_SORT;
            ST_DIV:  row_ctrl.op = ROW_HOLD;
            ST_EMIT: row_ctrl.op = emit_fire ? ROW_SHIFT : ROW_HOLD;
            default: row_ctrl.op = ROW_HOLD;
        endcase
    end

    // datapath next values
    always_comb begin
        hist_len_next = hist_len_reg;
        active_next   = active_reg;
        round_next    = round_reg;
        remain_next   = remain_reg;
        idx_next      = idx_reg;
        fix_idx_next  = fix_idx_reg;
        single_next   = single_reg;
        m_valid_next  = m_valid_reg;
        m_index_next  = m_index_reg;
        m_note_next   = m_note_reg;
        m_last_next   = m_last_reg;

        if (off_fire) begin
            active_next = act_dec;
            if (act_dec == '0) begin
                hist_len_next = '0;
            end
        end else if (on_fire) begin
            active_next   = act_inc;
            hist_len_next = len_inc;
            round_next    = '0;
            idx_next      = '0;
            single_next   = (mode_reg == MODE_PLAYED) || (mode_reg == MODE_PING);
            unique case (mode_reg)
                MODE_ASC, MODE_DESC: remain_next = n_sort;
                MODE_CHROM:          remain_next = steps_eff;
                default:             remain_next = CNT_W'(1);
            endcase
        end

        if (state_reg == ST_SORT) begin
            round_next = round_reg + CNT_W'(1);
        end

        if (div_done) begin
            if ((mode_reg == MODE_PLAYED) || (div_rem < 5'(steps_eff))) begin
                fix_idx_next = div_rem[IDX_W-1:0];
            end else begin
                fix_idx_next = IDX_W'(period - div_rem);
            end
        end

        if (emit_fire) begin
            m_valid_next = 1'b1;
            m_index_next = single_reg ? fix_idx_reg : idx_reg;
            m_note_next  = head.val;
            m_last_next  = (remain_reg == CNT_W'(1));
            remain_next  = remain_reg - CNT_W'(1);
            idx_next     = idx_reg + IDX_W'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_OFF;
            steps_cfg_reg <= CNT_W'(16);
            hist_len_reg  <= '0;
            active_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hist_len_reg <= hist_len_next;
            active_reg   <= active_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MODE) begin
                    mode_reg <= cfg_data[2:0];
                end else begin
                    steps_cfg_reg <= cfg_data;
                end
            end
        end
        round_reg   <= round_next;
        remain_reg  <= remain_next;
        idx_reg     <= idx_next;
        fix_idx_reg <= fix_idx_next;
        single_reg  <= single_next;
        m_index_reg <= m_index_next;
        m_note_reg  <= m_note_next;
        m_last_reg  <= m_last_next;
    end

    // newest-first history shift line
    always_ff @(posedge aclk) begin
        if (on_fire) begin
            hist_reg[0] <= note_in;
            for (int i = 1; i < MAX_STEPS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    hnstp_row #(
        .CELLS (CELLS)
    ) u_row (
        .aclk (aclk),
        .ctrl (row_ctrl),
        .ld   (ld),
        .head (head)
    );

    hnstp_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (act_inc - ACT_W'(1)),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, m_note_reg, m_index_reg};
    assign m_tlast   = m_last_reg;

endmodule

@@ rtl/hnstp_checker.sv @@
// Port-level checks for the held-note step table populator, bound to the top.
`include "held_note_step_table_populator_top_assert.svh"

module hnstp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    `HNSTP_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled write changed")

    `HNSTP_AST_NEXT(a_off_silent, s_tvalid && s_tready && s_tuser && !m_tvalid, !m_tvalid, "note-off produced a write")

    `HNSTP_AST_NOW(a_busy_cause, $fell(s_tready), $past(s_tvalid && s_tready && !s_tuser), "input blocked without a note-on")

    `HNSTP_AST_NOW(a_burst_closed, m_tvalid && !m_tlast, !s_tready, "input taken inside a write burst")

endmodule

bind held_note_step_table_populator_top hnstp_checker u_hnstp_checker (.*);
